>>> src/jss_pkg.sv
package jss_pkg;

	localparam int TABLE_ENTRIES_DEF = 1024;
	localparam int FRAC_BITS = 16;
	localparam int COUNT_W = 11;
	localparam int RATIO_W = FRAC_BITS + 1;
	localparam int KEY_W = 32;
	localparam logic [KEY_W-1:0] HASH_MUL = 32'h9E37_79B1;

	localparam logic [1:0] OP_ADD_A = 2'd0;
	localparam logic [1:0] OP_ADD_B = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic signed [KEY_W-1:0] element;
	} item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] intersection_count;
		logic [COUNT_W-1:0] union_count;
		logic [RATIO_W-1:0] jaccard_ratio;
		logic empty_flag;
		logic overflow_flag;
	} result_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_READ,
		S_PROBE,
		S_DIV,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic load_item;
		logic set_slot;
		logic probe;
		logic div_start;
		logic div_step;
		logic out_load;
		logic clr_start;
		logic clr_step;
	} cmd_t;

	typedef struct packed {
		logic probe_done;
		logic div_last;
		logic clr_last;
		logic out_busy;
	} stat_t;

endpackage

>>> src/jaccard_set_similarity.sv
// add beat: S_HASH, then S_READ and S_PROBE for each slot of the linear probe in turn
// finish beat: the bit-serial divider runs in S_DIV and S_EMIT loads the result register,
// then the table is cleared entry by entry before the next beat is taken
// a finish beat waits while an earlier result is still held in the output register
// reset: asynchronous active low; the table clear runs first
module jaccard_set_similarity #(
	parameter int TABLE_ENTRIES = jss_pkg::TABLE_ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  jss_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output jss_pkg::result_t result
);

	jss_pkg::cmd_t cmd;
	jss_pkg::stat_t stat;

	jss_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_op    (item.op),
		.stat       (stat),
		.item_stall (item_stall),
		.cmd        (cmd)
	);

	jss_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.result_stall (result_stall),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

>>> src/jss_ram.sv
module jss_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/jss_ctrl.sv
module jss_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  logic [1:0]     item_op,
	input  jss_pkg::stat_t stat,
	output logic           item_stall,
	output jss_pkg::cmd_t  cmd
);

	jss_pkg::state_t state_q, state_d;
	logic accept;

	assign item_stall = (state_q != jss_pkg::S_IDLE) ||
		((item_op == jss_pkg::OP_FINISH) && stat.out_busy);
	assign accept = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jss_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			jss_pkg::S_CLEAR: begin
				if (stat.clr_last) state_d = jss_pkg::S_IDLE;
			end
			jss_pkg::S_IDLE: begin
				if (accept) begin
					if (item_op == jss_pkg::OP_ADD_A || item_op == jss_pkg::OP_ADD_B) begin
						state_d = jss_pkg::S_HASH;
					end else if (item_op == jss_pkg::OP_FINISH) begin
						state_d = jss_pkg::S_DIV;
					end
				end
			end
			jss_pkg::S_HASH:  state_d = jss_pkg::S_READ;
			jss_pkg::S_READ:  state_d = jss_pkg::S_PROBE;
			jss_pkg::S_PROBE: begin
				state_d = stat.probe_done ? jss_pkg::S_IDLE : jss_pkg::S_READ;
			end
			jss_pkg::S_DIV: begin
				if (stat.div_last) state_d = jss_pkg::S_EMIT;
			end
			jss_pkg::S_EMIT:  state_d = jss_pkg::S_CLEAR;
			default:          state_d = jss_pkg::S_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			jss_pkg::S_CLEAR: cmd.clr_step = 1'b1;
			jss_pkg::S_IDLE: begin
				cmd.load_item = accept &&
					(item_op == jss_pkg::OP_ADD_A || item_op == jss_pkg::OP_ADD_B);
				cmd.div_start = accept && (item_op == jss_pkg::OP_FINISH);
			end
			jss_pkg::S_HASH:  cmd.set_slot = 1'b1;
			jss_pkg::S_READ:  cmd = '0;
			jss_pkg::S_PROBE: cmd.probe = 1'b1;
			jss_pkg::S_DIV:   cmd.div_step = 1'b1;
			jss_pkg::S_EMIT: begin
				cmd.out_load = 1'b1;
				cmd.clr_start = 1'b1;
			end
			default:          cmd = '0;
		endcase
	end

endmodule

>>> src/jss_dp.sv
module jss_dp #(
	parameter int TABLE_ENTRIES = jss_pkg::TABLE_ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  jss_pkg::item_t   item,
	input  jss_pkg::cmd_t    cmd,
	input  logic             result_stall,
	output jss_pkg::stat_t   stat,
	output logic             result_valid,
	output jss_pkg::result_t result
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int NUM_W = CNT_W + jss_pkg::FRAC_BITS;
	localparam int DC_W = $clog2(NUM_W);
	localparam int WORD_W = jss_pkg::KEY_W + 2;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [IDX_W:0] N_EXT = (IDX_W + 1)'(TABLE_ENTRIES);
	localparam logic [DC_W-1:0] DIV_LAST = DC_W'(NUM_W - 1);

	logic [jss_pkg::KEY_W-1:0] key_q, prod_q;
	logic [1:0] bit_q;
	logic [IDX_W-1:0] slot_q, tries_q, clr_addr_q;
	logic [CNT_W-1:0] cnt_a_q, cnt_b_q, cnt_both_q;
	logic ovf_q;
	logic [CNT_W-1:0] uni_q, inter_q, rem_q;
	logic [NUM_W-1:0] num_q;
	logic [DC_W-1:0] div_cnt_q;
	logic out_valid_q;
	jss_pkg::result_t out_q;

	logic we;
	logic [IDX_W-1:0] waddr;
	logic [WORD_W-1:0] wdata, rdata;
	logic [jss_pkg::KEY_W-1:0] rkey;
	logic [1:0] rbits, nbits;
	logic hit_empty, hit_match, last_try;
	logic [IDX_W-1:0] hash_idx, slot_fold;
	logic [IDX_W:0] hash_sub;
	logic [CNT_W:0] rem2, rem_diff, uni_sum;
	logic ge;

	jss_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (slot_q),
		.rdata (rdata)
	);

	assign rkey = rdata[WORD_W-1:2];
	assign rbits = rdata[1:0];
	assign nbits = rbits | bit_q;
	assign hit_empty = (rbits == 2'b00);
	assign hit_match = (rkey == key_q);
	assign last_try = (tries_q == LAST_IDX);

	assign hash_idx = prod_q[jss_pkg::KEY_W-1 -: IDX_W];
	assign hash_sub = {1'b0, hash_idx} - N_EXT;
	assign slot_fold = ({1'b0, hash_idx} >= N_EXT) ? hash_sub[IDX_W-1:0] : hash_idx;

	assign rem2 = {rem_q, num_q[NUM_W-1]};
	assign ge = (rem2 >= {1'b0, uni_q});
	assign rem_diff = rem2 - {1'b0, uni_q};
	assign uni_sum = {1'b0, cnt_a_q} + {1'b0, cnt_b_q} - {1'b0, cnt_both_q};

	always_comb begin
		we = 1'b0;
		waddr = slot_q;
		wdata = {key_q, bit_q};
		if (cmd.clr_step) begin
			we = 1'b1;
			waddr = clr_addr_q;
			wdata = '0;
		end else if (cmd.probe) begin
			if (hit_empty) begin
				we = 1'b1;
			end else if (hit_match && ((rbits & bit_q) == 2'b00)) begin
				we = 1'b1;
				wdata = {key_q, nbits};
			end
		end
	end

	assign stat.probe_done = hit_empty || hit_match || last_try;
	assign stat.div_last = (div_cnt_q == DIV_LAST);
	assign stat.clr_last = (clr_addr_q == LAST_IDX);
	assign stat.out_busy = out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			key_q <= item.element;
			bit_q <= (item.op == jss_pkg::OP_ADD_A) ? 2'b01 : 2'b10;
			prod_q <= item.element * jss_pkg::HASH_MUL;
		end
		if (cmd.div_start) begin
			uni_q <= uni_sum[CNT_W-1:0];
			inter_q <= cnt_both_q;
			num_q <= {cnt_both_q, {jss_pkg::FRAC_BITS{1'b0}}};
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? rem_diff[CNT_W-1:0] : rem2[CNT_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
		if (cmd.out_load) begin
			out_q.intersection_count <= jss_pkg::COUNT_W'(inter_q);
			out_q.union_count <= jss_pkg::COUNT_W'(uni_q);
			out_q.jaccard_ratio <= (uni_q == '0) ? '0 : jss_pkg::RATIO_W'(num_q);
			out_q.empty_flag <= (uni_q == '0);
			out_q.overflow_flag <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			tries_q <= '0;
			clr_addr_q <= '0;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			cnt_both_q <= '0;
			ovf_q <= 1'b0;
			div_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.set_slot) begin
				slot_q <= slot_fold;
				tries_q <= '0;
			end
			if (cmd.probe) begin
				if (hit_empty) begin
					if (bit_q[0]) cnt_a_q <= cnt_a_q + 1'b1;
					else cnt_b_q <= cnt_b_q + 1'b1;
				end else if (hit_match) begin
					if ((rbits & bit_q) == 2'b00) begin
						if (bit_q[0]) cnt_a_q <= cnt_a_q + 1'b1;
						else cnt_b_q <= cnt_b_q + 1'b1;
						if (nbits == 2'b11) cnt_both_q <= cnt_both_q + 1'b1;
					end
				end else if (last_try) begin
					ovf_q <= 1'b1;
				end else begin
					slot_q <= (slot_q == LAST_IDX) ? '0 : slot_q + 1'b1;
					tries_q <= tries_q + 1'b1;
				end
			end
			if (cmd.div_start) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (cmd.clr_start) begin
				clr_addr_q <= '0;
				cnt_a_q <= '0;
				cnt_b_q <= '0;
				cnt_both_q <= '0;
				ovf_q <= 1'b0;
			end else if (cmd.clr_step) begin
				clr_addr_q <= (clr_addr_q == LAST_IDX) ? '0 : clr_addr_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

endmodule
